[hw/rtl/kvp_pkg.sv]
// Shared types, character codes and helpers for the key/value parameter parser.
package kvp_pkg;

	localparam int FILL_W     = 7;
	localparam int INT_W      = 16;
	localparam int FRAC_W     = 20;
	localparam int FCNT_W     = 3;
	localparam int CODE_W     = 3;
	localparam int VALUE_W    = 32;
	localparam int MAG_W      = 33;
	localparam int CFG_IDX_W  = 1;

	localparam int FRAC_DIGITS_MAX = 6;
	localparam int DIV_IN_W        = 30;
	localparam int RECIP_W         = 31;
	localparam int RECIP_SHIFT     = 44;

	// Rounding a fraction over 10^6 is done with numerator and denominator divided by 2^6, and
	// the reciprocal of the remaining 15625 is exact for every numerator below 2^30.
	localparam logic [DIV_IN_W-1:0] ROUND_BIAS = 30'd7812;
	localparam logic [RECIP_W-1:0]  RECIP_MUL  = 31'd1125899907;

	localparam logic [CFG_IDX_W-1:0] REG_HEAD_CHAR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_CHAR  = 1'd1;

	localparam logic [7:0] HEAD_CHAR_RST = 8'd61;
	localparam logic [7:0] END_CHAR_RST  = 8'd10;

	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_I     = 8'h49;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_2     = 8'h32;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_WS_LO = 8'h09;
	localparam logic [7:0] CH_WS_HI = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	localparam logic [CODE_W-1:0] TGT_NONE = 3'd0;
	localparam logic [CODE_W-1:0] TGT_P1   = 3'd1;
	localparam logic [CODE_W-1:0] TGT_D1   = 3'd2;
	localparam logic [CODE_W-1:0] TGT_T1   = 3'd3;
	localparam logic [CODE_W-1:0] TGT_P2   = 3'd4;
	localparam logic [CODE_W-1:0] TGT_I2   = 3'd5;
	localparam logic [CODE_W-1:0] TGT_T2   = 3'd6;

	localparam logic [2:0] PH_SPACE = 3'd0;
	localparam logic [2:0] PH_SIGN  = 3'd1;
	localparam logic [2:0] PH_INT   = 3'd2;
	localparam logic [2:0] PH_FRAC  = 3'd3;
	localparam logic [2:0] PH_STOP  = 3'd4;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              negative;
		logic [INT_W-1:0]  int_part;
		logic [FRAC_W-1:0] frac;
		logic [FCNT_W-1:0] frac_cnt;
	} kvp_item_t;

	function automatic logic [FRAC_W-1:0] pow10(input logic [FCNT_W-1:0] n);
		logic [FRAC_W-1:0] r;
		unique case (n)
			3'd0: r = 20'd1;
			3'd1: r = 20'd10;
			3'd2: r = 20'd100;
			3'd3: r = 20'd1000;
			3'd4: r = 20'd10000;
			3'd5: r = 20'd100000;
			3'd6: r = 20'd1000000;
			default: r = 20'd1;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/kvp_parse.sv]
// Byte-level frame tracker: key capture, fill count and the running number parse.
module kvp_parse #(
	parameter int BUFFER_DEPTH    = 64,
	parameter int FRACTION_DIGITS = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [7:0]              head_char,
	input  logic [7:0]              end_char,
	input  logic                    byte_vld,
	input  logic [7:0]              byte_in,
	output logic                    res_valid,
	output kvp_pkg::kvp_item_t      res_item
);

	logic [7:0]                  prev_q, prev2_q, key1_q, key2_q;
	logic                        head_q, neg_q;
	logic [kvp_pkg::FILL_W-1:0]  fill_q;
	logic [2:0]                  phase_q;
	logic [kvp_pkg::INT_W-1:0]   int_q;
	logic [kvp_pkg::FRAC_W-1:0]  frac_q;
	logic [kvp_pkg::FCNT_W-1:0]  fcnt_q;

	logic [7:0]                  prev_n, prev2_n, key1_n, key2_n;
	logic                        head_n, neg_n;
	logic [kvp_pkg::FILL_W-1:0]  fill_n;
	logic [2:0]                  phase_n;
	logic [kvp_pkg::INT_W-1:0]   int_n;
	logic [kvp_pkg::FRAC_W-1:0]  frac_n;
	logic [kvp_pkg::FCNT_W-1:0]  fcnt_n;

	logic                        emit, clr, digit, is_ws;
	logic [3:0]                  dval;
	logic [19:0]                 int_t;
	logic [23:0]                 frac_t;
	logic [kvp_pkg::CODE_W-1:0]  code;

	always_comb begin
		priority if (key2_q == kvp_pkg::CH_1) begin
			priority if (key1_q == kvp_pkg::CH_P)      code = kvp_pkg::TGT_P1;
			else if (key1_q == kvp_pkg::CH_D)          code = kvp_pkg::TGT_D1;
			else if (key1_q == kvp_pkg::CH_T)          code = kvp_pkg::TGT_T1;
			else                                       code = kvp_pkg::TGT_NONE;
		end else if (key2_q == kvp_pkg::CH_2) begin
			priority if (key1_q == kvp_pkg::CH_P)      code = kvp_pkg::TGT_P2;
			else if (key1_q == kvp_pkg::CH_I)          code = kvp_pkg::TGT_I2;
			else if (key1_q == kvp_pkg::CH_T)          code = kvp_pkg::TGT_T2;
			else                                       code = kvp_pkg::TGT_NONE;
		end else begin
			code = kvp_pkg::TGT_NONE;
		end
	end

	always_comb begin
		digit  = (byte_in >= kvp_pkg::CH_0) && (byte_in <= kvp_pkg::CH_9);
		is_ws  = (byte_in == kvp_pkg::CH_SPACE) ||
		         ((byte_in >= kvp_pkg::CH_WS_LO) && (byte_in <= kvp_pkg::CH_WS_HI));
		dval   = digit ? 4'(byte_in - kvp_pkg::CH_0) : 4'd0;
		int_t  = ({4'd0, int_q} << 3) + ({4'd0, int_q} << 1) + {16'd0, dval};
		frac_t = ({4'd0, frac_q} << 3) + ({4'd0, frac_q} << 1) + {20'd0, dval};

		prev_n  = prev_q;
		prev2_n = prev2_q;
		key1_n  = key1_q;
		key2_n  = key2_q;
		head_n  = head_q;
		fill_n  = fill_q;
		phase_n = phase_q;
		neg_n   = neg_q;
		int_n   = int_q;
		frac_n  = frac_q;
		fcnt_n  = fcnt_q;
		emit    = 1'b0;
		clr     = 1'b0;

		priority if (byte_in == head_char) begin
			key1_n  = prev2_q;
			key2_n  = prev_q;
			head_n  = 1'b1;
			phase_n = kvp_pkg::PH_SPACE;
			neg_n   = 1'b0;
			int_n   = '0;
			frac_n  = '0;
			fcnt_n  = '0;
		end else if ((byte_in == end_char) && head_q) begin
			emit = 1'b1;
			clr  = 1'b1;
		end else if (head_q) begin
			unique case (phase_q)
				kvp_pkg::PH_SPACE: begin
					priority if (is_ws) begin
						phase_n = kvp_pkg::PH_SPACE;
					end else if ((byte_in == kvp_pkg::CH_PLUS) ||
					             (byte_in == kvp_pkg::CH_MINUS)) begin
						neg_n   = (byte_in == kvp_pkg::CH_MINUS);
						phase_n = kvp_pkg::PH_SIGN;
					end else if (digit) begin
						int_n   = {12'd0, dval};
						phase_n = kvp_pkg::PH_INT;
					end else if (byte_in == kvp_pkg::CH_DOT) begin
						phase_n = kvp_pkg::PH_FRAC;
					end else begin
						phase_n = kvp_pkg::PH_STOP;
					end
				end
				kvp_pkg::PH_SIGN, kvp_pkg::PH_INT: begin
					priority if (digit) begin
						int_n   = (int_t > 20'd65535) ? 16'hFFFF : int_t[15:0];
						phase_n = kvp_pkg::PH_INT;
					end else if (byte_in == kvp_pkg::CH_DOT) begin
						phase_n = kvp_pkg::PH_FRAC;
					end else begin
						phase_n = kvp_pkg::PH_STOP;
					end
				end
				kvp_pkg::PH_FRAC: begin
					if (digit) begin
						if (fcnt_q < kvp_pkg::FCNT_W'(FRACTION_DIGITS)) begin
							frac_n = frac_t[kvp_pkg::FRAC_W-1:0];
							fcnt_n = fcnt_q + 3'd1;
						end
					end else begin
						phase_n = kvp_pkg::PH_STOP;
					end
				end
				default: phase_n = kvp_pkg::PH_STOP;
			endcase
		end

		if (!emit) begin
			prev2_n = prev_q;
			prev_n  = byte_in;
			fill_n  = fill_q + 7'd1;
			if (fill_n >= kvp_pkg::FILL_W'(BUFFER_DEPTH)) begin
				clr = 1'b1;
			end
		end

		if (clr) begin
			prev_n  = '0;
			prev2_n = '0;
			key1_n  = '0;
			key2_n  = '0;
			head_n  = 1'b0;
			fill_n  = '0;
			phase_n = kvp_pkg::PH_SPACE;
			neg_n   = 1'b0;
			int_n   = '0;
			frac_n  = '0;
			fcnt_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			prev2_q <= '0;
			key1_q  <= '0;
			key2_q  <= '0;
			head_q  <= 1'b0;
			fill_q  <= '0;
			phase_q <= kvp_pkg::PH_SPACE;
			neg_q   <= 1'b0;
			int_q   <= '0;
			frac_q  <= '0;
			fcnt_q  <= '0;
		end else if (byte_vld) begin
			prev_q  <= prev_n;
			prev2_q <= prev2_n;
			key1_q  <= key1_n;
			key2_q  <= key2_n;
			head_q  <= head_n;
			fill_q  <= fill_n;
			phase_q <= phase_n;
			neg_q   <= neg_n;
			int_q   <= int_n;
			frac_q  <= frac_n;
			fcnt_q  <= fcnt_n;
		end
	end

	assign res_valid         = byte_vld && emit;
	assign res_item.code     = code;
	assign res_item.negative = neg_q;
	assign res_item.int_part = int_q;
	assign res_item.frac     = frac_q;
	assign res_item.frac_cnt = fcnt_q;

endmodule

[hw/rtl/kvp_fixcvt.sv]
// Pipelined decimal-fraction to fixed-point conversion with rounding and saturation.
module kvp_fixcvt #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  kvp_pkg::kvp_item_t            in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [kvp_pkg::CODE_W-1:0]    out_code,
	output logic [kvp_pkg::VALUE_W-1:0]   out_value
);

	localparam int FracShift = FRACTION_BITS - kvp_pkg::FRAC_DIGITS_MAX;
	localparam int ProdW     = kvp_pkg::DIV_IN_W + kvp_pkg::RECIP_W;
	localparam logic [kvp_pkg::MAG_W-1:0] PosMax = 33'h0_7FFF_FFFF;
	localparam logic [kvp_pkg::MAG_W-1:0] NegMax = 33'h0_8000_0000;

	logic                         vld_s1, rdy_s1;
	logic [kvp_pkg::CODE_W-1:0]   code_s1;
	logic                         neg_s1;
	logic [kvp_pkg::INT_W-1:0]    intp_s1;
	logic [kvp_pkg::DIV_IN_W-1:0] num_s1;

	logic                         vld_s2, rdy_s2;
	logic [kvp_pkg::CODE_W-1:0]   code_s2;
	logic                         neg_s2;
	logic [kvp_pkg::MAG_W-1:0]    mag_s2;

	logic                         out_valid_q, out_rdy;
	logic [kvp_pkg::CODE_W-1:0]   out_code_q;
	logic [kvp_pkg::VALUE_W-1:0]  out_value_q;

	logic [2*kvp_pkg::FRAC_W-1:0] frac_prod;
	logic [kvp_pkg::DIV_IN_W-1:0] num_n;
	logic [ProdW-1:0]             quo_prod;
	logic [FRACTION_BITS:0]       quo;
	logic [kvp_pkg::MAG_W-1:0]    mag_n, neg_mag;

	// The fraction is brought to a denominator of 10^6 before the rounded division.
	always_comb begin
		frac_prod = (2*kvp_pkg::FRAC_W)'(in_item.frac) *
		            (2*kvp_pkg::FRAC_W)'(kvp_pkg::pow10(
		                kvp_pkg::FCNT_W'(kvp_pkg::FRAC_DIGITS_MAX) - in_item.frac_cnt));
		num_n     = (kvp_pkg::DIV_IN_W'(frac_prod[kvp_pkg::FRAC_W-1:0]) << FracShift) +
		            kvp_pkg::ROUND_BIAS;
		quo_prod  = ProdW'(num_s1) * ProdW'(kvp_pkg::RECIP_MUL);
		quo       = quo_prod[kvp_pkg::RECIP_SHIFT +: FRACTION_BITS + 1];
		mag_n     = kvp_pkg::MAG_W'({intp_s1, {FRACTION_BITS{1'b0}}}) +
		            kvp_pkg::MAG_W'(quo);
		neg_mag   = '0 - mag_s2;
	end

	assign in_ready = rdy_s1;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign rdy_s2   = !vld_s2 || out_rdy;
	assign out_rdy  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= in_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (out_rdy) begin
				out_valid_q <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			code_s1 <= in_item.code;
			neg_s1  <= in_item.negative;
			intp_s1 <= in_item.int_part;
			num_s1  <= num_n;
		end
		if (rdy_s2) begin
			code_s2 <= code_s1;
			neg_s2  <= neg_s1;
			mag_s2  <= mag_n;
		end
		if (out_rdy) begin
			out_code_q <= code_s2;
			if (neg_s2) begin
				out_value_q <= (mag_s2 > NegMax) ? 32'h8000_0000 : neg_mag[31:0];
			end else begin
				out_value_q <= (mag_s2 > PosMax) ? 32'h7FFF_FFFF : mag_s2[31:0];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_code  = out_code_q;
	assign out_value = out_value_q;

endmodule

[hw/rtl/ascii_key_value_param_parser_unit.sv]
// Top level of the key/value parameter parser: configuration registers and stream ports.
// Takes one received byte per cycle while s_tready is high and recognizes frames of
// the form key, head character, decimal number, end character. Every byte is absorbed in
// the cycle it is transferred; the byte that ends a frame launches a result into a
// conversion pipeline of two stages and an output register: the first brings the decimal
// fraction to a common denominator, the second divides by reciprocal multiplication with
// rounding and adds the integer part, and the output register saturates the signed value.
// A result is offered once it has passed both stages and the output register; the stages
// fill independently, so input is only held back when all of them hold untaken results.
// The target code travels on m_tuser and the signed fixed-point value on m_tdata.
module ascii_key_value_param_parser_unit #(
	parameter int BUFFER_DEPTH    = 64,
	parameter int FRACTION_DIGITS = 6,
	parameter int FRACTION_BITS   = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [7:0] rx_byte
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [31:0]                     m_tdata,   // [31:0] value
	output logic [7:0]                      m_tuser,   // [2:0] target_code
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [kvp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [7:0]                      cfg_data
);

	logic [7:0]                 head_char_q, end_char_q;
	logic                       byte_vld, res_valid;
	kvp_pkg::kvp_item_t         res_item;
	logic [kvp_pkg::CODE_W-1:0] code;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_char_q <= kvp_pkg::HEAD_CHAR_RST;
			end_char_q  <= kvp_pkg::END_CHAR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				kvp_pkg::REG_HEAD_CHAR: head_char_q <= cfg_data;
				kvp_pkg::REG_END_CHAR:  end_char_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign byte_vld = s_tvalid && s_tready;

	kvp_parse #(
		.BUFFER_DEPTH    (BUFFER_DEPTH),
		.FRACTION_DIGITS (FRACTION_DIGITS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_char (head_char_q),
		.end_char  (end_char_q),
		.byte_vld  (byte_vld),
		.byte_in   (s_tdata),
		.res_valid (res_valid),
		.res_item  (res_item)
	);

	kvp_fixcvt #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_fixcvt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_ready  (s_tready),
		.in_item   (res_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_code  (code),
		.out_value (m_tdata)
	);

	assign m_tuser = {5'd0, code};

endmodule

[tb/ascii_key_value_param_parser_unit_tb.sv]
`timescale 1ns / 100ps
// Testbench for the key/value parameter parser: directed frames, then random byte traffic.
module ascii_key_value_param_parser_unit_tb;

	localparam int BUFFER_DEPTH    = 64;
	localparam int FRACTION_DIGITS = 6;
	localparam int FRACTION_BITS   = 16;
	localparam int SETTLE_CYCLES   = 16;
	localparam int LIMIT_CYCLES    = 400000;
	localparam int N_PHASES        = 8;
	localparam int N_DIRECTED      = 28;

	typedef struct packed {
		logic [kvp_pkg::CODE_W-1:0]  code;
		logic [kvp_pkg::VALUE_W-1:0] value;
	} frame_result_t;

	typedef struct packed {
		logic [7:0]                  b;
		logic                        typed;
		logic [kvp_pkg::CODE_W-1:0]  code;
		logic [kvp_pkg::VALUE_W-1:0] value;
	} stim_row_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	logic [7:0]                    s_tdata   = 8'd0;
	logic                          m_tvalid;
	logic                          m_tready  = 1'b0;
	logic [31:0]                   m_tdata;
	logic [7:0]                    m_tuser;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [kvp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]                    cfg_data  = 8'd0;

	ascii_key_value_param_parser_unit #(
		.BUFFER_DEPTH(BUFFER_DEPTH),
		.FRACTION_DIGITS(FRACTION_DIGITS),
		.FRACTION_BITS(FRACTION_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	stim_row_t directed_rows [N_DIRECTED] = '{
		'{"Z",                    1'b0, kvp_pkg::TGT_NONE, 32'd0},
		'{"Z",                    1'b0, kvp_pkg::TGT_NONE, 32'd0},
		'{kvp_pkg::HEAD_CHAR_RST, 1'b0, kvp_pkg::TGT_NONE, 32'd0},
		'{kvp_pkg::END_CHAR_RST,  1'b1, kvp_pkg::TGT_NONE, 32'd0},
		'{kvp_pkg::CH_I,          1'b0, kvp_pkg::TGT_NONE, 32'd0},
		'{kvp_pkg::CH_2,          1'b0, kvp_pkg::TGT_NONE, 32'd0},
		'{kvp_pkg::HEAD_CHAR_RST, 1'b0, kvp_pkg::TGT_NONE, 32'd0},
		'{kvp_pkg::CH_9,          1'b0, kvp_pkg::TGT_NONE, 32'd0},
		'{kvp_pkg::CH_9,          1'b0, kvp_pkg::TGT_NONE, 32'd0},
		'{kvp_pkg::CH_9,          1'b0, kvp_pkg::TGT_NONE, 32'd0},
		'{kvp_pkg::CH_9,          1'b0, kvp_pkg::TGT_NONE, 32'd0},
		'{kvp_pkg::CH_9,          1'b0, kvp_pkg::TGT_NONE, 32'd0},
		'{kvp_pkg::END_CHAR_RST,  1'b1, kvp_pkg::TGT_I2,   32'h7FFF_FFFF},
		'{kvp_pkg::CH_T,          1'b0, kvp_pkg::TGT_NONE, 32'd0},
		'{kvp_pkg::CH_2,          1'b0, kvp_pkg::TGT_NONE, 32'd0},
		'{kvp_pkg::HEAD_CHAR_RST, 1'b0, kvp_pkg::TGT_NONE, 32'd0},
		'{kvp_pkg::CH_MINUS,      1'b0, kvp_pkg::TGT_NONE, 32'd0},
		'{kvp_pkg::CH_9,          1'b0, kvp_pkg::TGT_NONE, 32'd0},
		'{kvp_pkg::CH_9,          1'b0, kvp_pkg::TGT_NONE, 32'd0},
		'{kvp_pkg::CH_9,          1'b0, kvp_pkg::TGT_NONE, 32'd0},
		'{kvp_pkg::CH_9,          1'b0, kvp_pkg::TGT_NONE, 32'd0},
		'{kvp_pkg::CH_9,          1'b0, kvp_pkg::TGT_NONE, 32'd0},
		'{kvp_pkg::END_CHAR_RST,  1'b1, kvp_pkg::TGT_T2,   32'h8000_0000},
		'{kvp_pkg::CH_D,          1'b0, kvp_pkg::TGT_NONE, 32'd0},
		'{kvp_pkg::CH_1,          1'b0, kvp_pkg::TGT_NONE, 32'd0},
		'{kvp_pkg::HEAD_CHAR_RST, 1'b0, kvp_pkg::TGT_NONE, 32'd0},
		'{kvp_pkg::CH_MINUS,      1'b0, kvp_pkg::TGT_NONE, 32'd0},
		'{kvp_pkg::END_CHAR_RST,  1'b1, kvp_pkg::TGT_D1,   32'd0}
	};

	logic [7:0] phase_head   [N_PHASES] = '{8'd61, 8'd61, 8'd58, 8'd0, 8'd255, 8'd33, 8'd61, 8'd61};
	logic [7:0] phase_end    [N_PHASES] = '{8'd10, 8'd10, 8'd59, 8'd255, 8'd0, 8'd33, 8'd13, 8'd10};
	int         phase_send   [N_PHASES] = '{0, 88, 0, 14, 0, 14, 0, 88};
	int         phase_recv   [N_PHASES] = '{0, 0, 88, 14, 0, 14, 88, 0};
	int         phase_budget [N_PHASES] = '{180, 170, 170, 170, 170, 90, 170, 170};

	logic [7:0] key_firsts  [6] = '{kvp_pkg::CH_P, kvp_pkg::CH_D, kvp_pkg::CH_T,
	                                kvp_pkg::CH_P, kvp_pkg::CH_I, kvp_pkg::CH_T};
	logic [7:0] key_seconds [6] = '{kvp_pkg::CH_1, kvp_pkg::CH_1, kvp_pkg::CH_1,
	                                kvp_pkg::CH_2, kvp_pkg::CH_2, kvp_pkg::CH_2};

	frame_result_t expected_frames [$];
	stim_row_t     cur_row = '0;
	int            send_idle_pct  = 0;
	int            recv_stall_pct = 0;
	logic [7:0]    gen_head = kvp_pkg::HEAD_CHAR_RST;
	logic [7:0]    gen_end  = kvp_pkg::END_CHAR_RST;
	int            bytes_sent      = 0;
	int            frames_sent     = 0;
	int            results_checked = 0;
	int            mismatches      = 0;
	int            cycle_count     = 0;
	int            code_hits [8]   = '{default: 0};

	// Decoder model state.
	logic [7:0]                 model_head;
	logic [7:0]                 model_end;
	logic [7:0]                 prev_b;
	logic [7:0]                 prev2_b;
	logic [7:0]                 key_hi;
	logic [7:0]                 key_lo;
	logic                       head_seen;
	logic [kvp_pkg::FILL_W-1:0] fill_cnt;
	logic [2:0]                 num_phase;
	logic                       neg;
	logic [kvp_pkg::INT_W-1:0]  int_acc;
	logic [kvp_pkg::FRAC_W-1:0] frac_acc;
	logic [kvp_pkg::FCNT_W-1:0] frac_cnt;

	function automatic void number_restart();
		num_phase = kvp_pkg::PH_SPACE;
		neg       = 1'b0;
		int_acc   = '0;
		frac_acc  = '0;
		frac_cnt  = '0;
	endfunction

	function automatic void frame_clear();
		prev_b    = 8'd0;
		prev2_b   = 8'd0;
		key_hi    = 8'd0;
		key_lo    = 8'd0;
		head_seen = 1'b0;
		fill_cnt  = '0;
		number_restart();
	endfunction

	function automatic void number_feed(input logic [7:0] b);
		logic        is_digit;
		logic [31:0] d;
		logic [31:0] t;
		is_digit = (b >= kvp_pkg::CH_0) && (b <= kvp_pkg::CH_9);
		d = is_digit ? 32'(b - kvp_pkg::CH_0) : 32'd0;
		case (num_phase)
			kvp_pkg::PH_SPACE: begin
				if (b == kvp_pkg::CH_SPACE ||
				    (b >= kvp_pkg::CH_WS_LO && b <= kvp_pkg::CH_WS_HI)) begin
				end else if (b == kvp_pkg::CH_PLUS || b == kvp_pkg::CH_MINUS) begin
					neg = (b == kvp_pkg::CH_MINUS);
					num_phase = kvp_pkg::PH_SIGN;
				end else if (is_digit) begin
					int_acc = d[kvp_pkg::INT_W-1:0];
					num_phase = kvp_pkg::PH_INT;
				end else if (b == kvp_pkg::CH_DOT) begin
					num_phase = kvp_pkg::PH_FRAC;
				end else begin
					num_phase = kvp_pkg::PH_STOP;
				end
			end
			kvp_pkg::PH_SIGN, kvp_pkg::PH_INT: begin
				if (is_digit) begin
					t = 32'(int_acc) * 32'd10 + d;
					int_acc = (t > 32'd65535) ? 16'hFFFF : t[kvp_pkg::INT_W-1:0];
					num_phase = kvp_pkg::PH_INT;
				end else if (b == kvp_pkg::CH_DOT) begin
					num_phase = kvp_pkg::PH_FRAC;
				end else begin
					num_phase = kvp_pkg::PH_STOP;
				end
			end
			kvp_pkg::PH_FRAC: begin
				if (is_digit) begin
					if (frac_cnt < FRACTION_DIGITS) begin
						frac_acc = kvp_pkg::FRAC_W'(32'(frac_acc) * 32'd10 + d);
						frac_cnt = frac_cnt + 1'b1;
					end
				end else begin
					num_phase = kvp_pkg::PH_STOP;
				end
			end
			default: num_phase = kvp_pkg::PH_STOP;
		endcase
	endfunction

	function automatic logic [kvp_pkg::CODE_W-1:0] key_target();
		if (key_lo == kvp_pkg::CH_1) begin
			if (key_hi == kvp_pkg::CH_P) return kvp_pkg::TGT_P1;
			if (key_hi == kvp_pkg::CH_D) return kvp_pkg::TGT_D1;
			if (key_hi == kvp_pkg::CH_T) return kvp_pkg::TGT_T1;
		end else if (key_lo == kvp_pkg::CH_2) begin
			if (key_hi == kvp_pkg::CH_P) return kvp_pkg::TGT_P2;
			if (key_hi == kvp_pkg::CH_I) return kvp_pkg::TGT_I2;
			if (key_hi == kvp_pkg::CH_T) return kvp_pkg::TGT_T2;
		end
		return kvp_pkg::TGT_NONE;
	endfunction

	function automatic logic [kvp_pkg::VALUE_W-1:0] q16_value();
		longint unsigned scale;
		longint unsigned fq;
		longint unsigned mag;
		longint          v;
		scale = 1;
		for (int i = 0; i < frac_cnt && i < FRACTION_DIGITS; i++)
			scale = scale * 10;
		fq  = ((64'(frac_acc) << FRACTION_BITS) + scale / 2) / scale;
		mag = (64'(int_acc) << FRACTION_BITS) + fq;
		if (neg)
			v = (mag > 64'd2147483648) ? -64'sd2147483648 : -longint'(mag);
		else
			v = (mag > 64'd2147483647) ? 64'sd2147483647 : longint'(mag);
		return v[kvp_pkg::VALUE_W-1:0];
	endfunction

	function automatic bit decode_byte(input logic [7:0] b, output frame_result_t r);
		r = '0;
		if (b == model_head) begin
			key_hi    = prev2_b;
			key_lo    = prev_b;
			head_seen = 1'b1;
			number_restart();
		end else if (b == model_end && head_seen) begin
			r.code  = key_target();
			r.value = q16_value();
			frame_clear();
			return 1'b1;
		end else if (head_seen) begin
			number_feed(b);
		end
		prev2_b  = prev_b;
		prev_b   = b;
		fill_cnt = fill_cnt + 1'b1;
		if (fill_cnt >= BUFFER_DEPTH)
			frame_clear();
		return 1'b0;
	endfunction

	always @(posedge clk) begin
		frame_result_t r;
		frame_result_t want;
		if (!arst_n) begin
			model_head = kvp_pkg::HEAD_CHAR_RST;
			model_end  = kvp_pkg::END_CHAR_RST;
			frame_clear();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == kvp_pkg::REG_HEAD_CHAR)
					model_head = cfg_data;
				else if (cfg_index == kvp_pkg::REG_END_CHAR)
					model_end = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				if (decode_byte(s_tdata, r)) begin
					if (cur_row.typed)
						r = '{code: cur_row.code, value: cur_row.value};
					expected_frames.push_back(r);
				end
			end
			if (m_tvalid && m_tready) begin
				if (expected_frames.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result: tuser %h tdata %h", m_tuser, m_tdata);
				end else begin
					want = expected_frames.pop_front();
					results_checked++;
					code_hits[want.code]++;
					if (m_tuser !== {5'd0, want.code} || m_tdata !== want.value) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: tuser %h (expected %h), tdata %h (expected %h)",
								m_tuser, {5'd0, want.code}, m_tdata, want.value);
					end
				end
			end
		end
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_frames.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic stim_row_t plain(input logic [7:0] b);
		return '{b: b, typed: 1'b0, code: kvp_pkg::TGT_NONE, value: '0};
	endfunction

	task automatic send_item(input stim_row_t row);
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= row.b;
		cur_row  <= row;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	task automatic write_reg(input logic [kvp_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_frame();
		int         kind;
		int         n;
		int         sel;
		logic [7:0] k1;
		logic [7:0] k2;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			n = $urandom_range(1, 8);
			repeat (n) send_item(plain(8'($urandom_range(0, 255))));
		end else if (kind < 11) begin
			n = $urandom_range(60, 72);
			repeat (n) send_item(plain(8'($urandom_range(0, 255))));
		end else begin
			sel = $urandom_range(0, 9);
			if (sel < 8) begin
				n  = $urandom_range(0, 5);
				k1 = key_firsts[n];
				k2 = key_seconds[n];
			end else if (sel == 8) begin
				k1 = key_firsts[$urandom_range(0, 5)];
				k2 = key_seconds[$urandom_range(0, 5)];
			end else begin
				k1 = 8'($urandom_range(0, 255));
				k2 = 8'($urandom_range(0, 255));
			end
			send_item(plain(k1));
			send_item(plain(k2));
			send_item(plain(gen_head));
			if ($urandom_range(0, 3) == 3) begin
				n = $urandom_range(1, 3);
				repeat (n) begin
					sel = $urandom_range(8, 13);
					send_item(plain((sel == 8) ? kvp_pkg::CH_SPACE : 8'(sel)));
				end
			end
			sel = $urandom_range(0, 3);
			if (sel == 1)
				send_item(plain(kvp_pkg::CH_PLUS));
			else if (sel == 2)
				send_item(plain(kvp_pkg::CH_MINUS));
			sel = $urandom_range(0, 9);
			n = (sel < 1) ? 0 : (sel < 8) ? $urandom_range(1, 3) : $urandom_range(4, 6);
			repeat (n) send_item(plain(kvp_pkg::CH_0 + 8'($urandom_range(0, 9))));
			if ($urandom_range(0, 9) < 6) begin
				send_item(plain(kvp_pkg::CH_DOT));
				n = $urandom_range(0, 8);
				repeat (n) send_item(plain(kvp_pkg::CH_0 + 8'($urandom_range(0, 9))));
			end
			if ($urandom_range(0, 99) < 15) begin
				send_item(plain(8'($urandom_range(0, 255))));
				send_item(plain(kvp_pkg::CH_0 + 8'($urandom_range(0, 9))));
			end
			if (kind >= 20)
				send_item(plain(gen_end));
		end
	endtask

	initial begin
		int start;
		int frames;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < N_PHASES; p++) begin
			if (p != 0) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while (expected_frames.size() != 0);
				repeat (SETTLE_CYCLES) @(posedge clk);
				write_reg(kvp_pkg::REG_HEAD_CHAR, phase_head[p]);
				write_reg(kvp_pkg::REG_END_CHAR, phase_end[p]);
			end
			send_idle_pct  = phase_send[p];
			recv_stall_pct = phase_recv[p];
			gen_head       = phase_head[p];
			gen_end        = phase_end[p];
			if (p == 0)
				for (int i = 0; i < N_DIRECTED; i++)
					send_item(directed_rows[i]);
			start  = bytes_sent;
			frames = 0;
			while (bytes_sent - start < phase_budget[p]) begin
				send_frame();
				frames++;
				if (frames % 25 == 0) begin
					s_tvalid <= 1'b0;
					do @(posedge clk); while (expected_frames.size() != 0);
				end
			end
			frames_sent += frames;
		end
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_frames.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d bytes in %0d random frames over %0d delimiter and idle settings;",
			bytes_sent, frames_sent, N_PHASES);
		$display("%0d results compared. Targets seen: none %0d, P1 %0d, D1 %0d, T1 %0d,",
			results_checked, code_hits[0], code_hits[1], code_hits[2], code_hits[3]);
		$display("P2 %0d, I2 %0d, T2 %0d; mismatches %0d.",
			code_hits[4], code_hits[5], code_hits[6], mismatches);
		if (mismatches == 0 && expected_frames.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[ascii_key_value_param_parser_unit.f]
hw/rtl/kvp_pkg.sv
hw/rtl/kvp_parse.sv
hw/rtl/kvp_fixcvt.sv
hw/rtl/ascii_key_value_param_parser_unit.sv
tb/ascii_key_value_param_parser_unit_tb.sv
